// ----- sv/deq_pkg.sv -----
package deq_pkg;

  // Widths of the payload fields
  localparam int unsigned DataW = 32;
  localparam int unsigned KindW = 2;

  // Operation codes carried on the input tuser
  typedef enum logic [KindW-1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_BACK   = 2'd2,
    KIND_POP_FRONT  = 2'd3
  } deq_kind_e;

  // What one storage cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_LOAD    = 2'd1,
    CELL_FROM_LO = 2'd2,
    CELL_FROM_HI = 2'd3
  } deq_cell_cmd_e;

  // Row-wide control broadcast to every cell of one row
  typedef struct packed {
    logic shift_up;  // every cell takes its lower neighbor, new word enters at cell 0
    logic shift_dn;  // every cell takes its upper neighbor, new word enters at the top cell
    logic wr_en;     // write the new word into the addressed cell only
  } deq_row_ctrl_t;

endpackage

// ----- sv/deq_cell.sv -----
module deq_cell (
  input  logic                          clk_i,
  input  deq_pkg::deq_cell_cmd_e        cmd_i,
  input  logic [deq_pkg::DataW-1:0]     load_i,
  input  logic [deq_pkg::DataW-1:0]     lo_i,
  input  logic [deq_pkg::DataW-1:0]     hi_i,
  output logic [deq_pkg::DataW-1:0]     data_o,
  output logic [deq_pkg::DataW-1:0]     data_d_o
);

  logic [deq_pkg::DataW-1:0] data_q;
  logic [deq_pkg::DataW-1:0] data_d;

  // Select the next content of this cell
  always_comb begin
    case (cmd_i)
      deq_pkg::CELL_LOAD:    data_d = load_i;
      deq_pkg::CELL_FROM_LO: data_d = lo_i;
      deq_pkg::CELL_FROM_HI: data_d = hi_i;
      default:               data_d = data_q;
    endcase
  end

  // Hold the stored word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o   = data_q;
  assign data_d_o = data_d;

endmodule

// ----- sv/deq_row.sv -----
module deq_row #(
  parameter int unsigned DEPTH      = 16,
  parameter bit          BackAligned = 1'b0
) (
  input  logic                              clk_i,
  input  deq_pkg::deq_row_ctrl_t            ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]          wr_idx_i,
  input  logic [deq_pkg::DataW-1:0]         wdata_i,
  output logic [deq_pkg::DataW-1:0]         end_d_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [deq_pkg::DataW-1:0] cell_q [DEPTH];
  logic [deq_pkg::DataW-1:0] cell_d [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_pkg::deq_cell_cmd_e    cmd;
    logic [deq_pkg::DataW-1:0] lo;
    logic [deq_pkg::DataW-1:0] hi;

    // Decode the row command for this cell
    always_comb begin
      if (ctrl_i.shift_up) begin
        cmd = deq_pkg::CELL_FROM_LO;
      end else if (ctrl_i.shift_dn) begin
        cmd = deq_pkg::CELL_FROM_HI;
      end else if (ctrl_i.wr_en && (wr_idx_i == IdxW'(i))) begin
        cmd = deq_pkg::CELL_LOAD;
      end else begin
        cmd = deq_pkg::CELL_HOLD;
      end
    end

    // The new word enters at either end of the row
    if (i == 0) begin : g_lo_end
      assign lo = wdata_i;
    end else begin : g_lo_mid
      assign lo = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_end
      assign hi = wdata_i;
    end else begin : g_hi_mid
      assign hi = cell_q[i+1];
    end

    deq_cell u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .load_i   (wdata_i),
      .lo_i     (lo),
      .hi_i     (hi),
      .data_o   (cell_q[i]),
      .data_d_o (cell_d[i])
    );
  end

  // Expose the next content of the cell that holds the aligned end
  if (BackAligned) begin : g_end_hi
    assign end_d_o = cell_d[DEPTH-1];
  end else begin : g_end_lo
    assign end_d_o = cell_d[0];
  end

endmodule

// ----- sv/double_ended_queue_top.sv -----
// Bounded deque of 32-bit signed words, DEPTH entries (2 to 4096). Each input word is
// one operation (tuser: 0 push back, 1 push front, 2 pop back, 3 pop front; tdata:
// the value to push) and gives exactly one result word: front and back values after
// the operation (zero when empty), empty, full and error flags. A pop on an empty
// deque or a push on a full one is refused with the error flag set and no change.
// The entries sit in two rows of cells: one row keeps the front at its lowest cell,
// the other keeps the back at its highest cell, so both ends are read at fixed cells.
// One operation per cycle is accepted while no skid word waits; each result is
// registered, in the skid word while the output word is held, so the two-word output
// buffer keeps the input open while one result waits. No clearing pass after reset.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: [31:0] data_value
  input  logic [31:0] s_axis_tdata,
  // s_axis_tuser: [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // m_axis_tdata: [31:0] front_value, [63:32] back_value, [64] empty_flag,
  //               [65] full_flag, [66] error_flag, [71:67] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned ResW  = 2 * deq_pkg::DataW + 3;
  localparam int unsigned PadW  = 72 - ResW;

  deq_pkg::deq_kind_e  kind;
  logic                accept;
  logic                take;
  logic                is_full;
  logic                cnt_zero;
  logic                err;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     count_d;
  logic [IdxW-1:0]     front_wr_idx;
  logic [IdxW-1:0]     back_wr_idx;
  deq_pkg::deq_row_ctrl_t front_ctrl;
  deq_pkg::deq_row_ctrl_t back_ctrl;
  logic [deq_pkg::DataW-1:0] front_d;
  logic [deq_pkg::DataW-1:0] back_d;
  logic [ResW-1:0]     res;
  logic [ResW-1:0]     out_q;
  logic [ResW-1:0]     skid_q;
  logic                out_vld_q;
  logic                skid_vld_q;

  assign kind     = deq_pkg::deq_kind_e'(s_axis_tuser);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign take     = out_vld_q && m_axis_tready;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign cnt_zero = (count_q == '0);

  assign front_wr_idx = count_q[IdxW-1:0];
  assign back_wr_idx  = IdxW'(DEPTH - 1) - count_q[IdxW-1:0];

  // Decode the operation into row controls and the new count
  always_comb begin
    err        = 1'b0;
    count_d    = count_q;
    front_ctrl = '0;
    back_ctrl  = '0;
    if (accept) begin
      case (kind)
        deq_pkg::KIND_PUSH_BACK: begin
          if (is_full) begin
            err = 1'b1;
          end else begin
            front_ctrl.wr_en = 1'b1;
            back_ctrl.shift_dn = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        deq_pkg::KIND_PUSH_FRONT: begin
          if (is_full) begin
            err = 1'b1;
          end else begin
            front_ctrl.shift_up = 1'b1;
            back_ctrl.wr_en = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        deq_pkg::KIND_POP_BACK: begin
          if (cnt_zero) begin
            err = 1'b1;
          end else begin
            back_ctrl.shift_up = 1'b1;
            count_d = count_q - CntW'(1);
          end
        end
        default: begin
          if (cnt_zero) begin
            err = 1'b1;
          end else begin
            front_ctrl.shift_dn = 1'b1;
            count_d = count_q - CntW'(1);
          end
        end
      endcase
    end
  end

  // Front-aligned row: front entry always in cell 0
  deq_row #(
    .DEPTH       (DEPTH),
    .BackAligned (1'b0)
  ) u_front_row (
    .clk_i     (clk_i),
    .ctrl_i    (front_ctrl),
    .wr_idx_i  (front_wr_idx),
    .wdata_i   (s_axis_tdata),
    .end_d_o   (front_d)
  );

  // Back-aligned row: back entry always in the top cell
  deq_row #(
    .DEPTH       (DEPTH),
    .BackAligned (1'b1)
  ) u_back_row (
    .clk_i     (clk_i),
    .ctrl_i    (back_ctrl),
    .wr_idx_i  (back_wr_idx),
    .wdata_i   (s_axis_tdata),
    .end_d_o   (back_d)
  );

  // Assemble the result word from the state after the operation
  always_comb begin
    res = {err, (count_d == CntW'(DEPTH)), (count_d == '0),
           ((count_d == '0) ? {deq_pkg::DataW{1'b0}} : back_d),
           ((count_d == '0) ? {deq_pkg::DataW{1'b0}} : front_d)};
  end

  // Hold the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Advance the output buffer valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= accept;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Move result words through the output buffer
  always_ff @(posedge clk_i) begin
    if (take || !out_vld_q) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready = !skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_q};

  // Count never exceeds the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond capacity");

  // Skid word only exists behind a valid output word
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word without output word");

  // Refused operation leaves the count unchanged
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && err) |=> (count_q == $past(count_q)))
    else $error("refused operation changed the count");

  // Accepted operation that is not refused changes the count
  a_ok_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !err) |=> (count_q != $past(count_q)))
    else $error("accepted operation left the count unchanged");

  // Every accepted word shows up in the output buffer next cycle
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_vld_q)
    else $error("result word lost");

endmodule
